@@ hw/rtl/eoe_pkg.sv @@
// ----------------------------------------------------------------------------
// Elias omega encoder package
// Shared widths, command and status types and a helper function.
// ----------------------------------------------------------------------------
package eoe_pkg;

  localparam int unsigned VALUE_WIDTH  = 32;
  localparam int unsigned OFFSET_WIDTH = 32;
  // Longest code plus the seven waiting bits, with margin for wider values.
  localparam int unsigned BUF_W        = VALUE_WIDTH + 24;
  localparam int unsigned CNT_W        = $clog2(BUF_W + 1);
  localparam int unsigned LEN_W        = $clog2(VALUE_WIDTH + 1);
  localparam int unsigned BYTE_W       = 8;
  localparam int unsigned PEND_W       = 7;
  localparam int unsigned PCNT_W       = 3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // take a new item and set up the code buffer
    logic step;       // prepend one length group, or the waiting bits
    logic mark;       // send the zero-value marker
    logic emit_byte;  // send the oldest full byte of the buffer
    logic emit_pad;   // send the partial byte padded with zeros
    logic finish;     // keep the leftover bits for the next item
  } eoe_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic cur_zero;
    logic cur_gt1;
    logic cnt_ge8;
    logic cnt_nz;
    logic flush;
    logic out_free;
  } eoe_status_t;

  // Number of significant bits of a value.
  function automatic logic [LEN_W-1:0] bit_length(input logic [VALUE_WIDTH-1:0] n);
    logic [LEN_W-1:0] len;
    len = '0;
    for (int i = 0; i < VALUE_WIDTH; i++) begin
      if (n[i]) begin
        len = LEN_W'(i + 1);
      end
    end
    return len;
  endfunction

endpackage

@@ hw/rtl/elias_omega_encoder_unit.sv @@
// ----------------------------------------------------------------------------
// Elias omega encoder unit
// Codes unsigned integers into a packed, MSB-first Elias omega byte stream.
// ----------------------------------------------------------------------------
// Each transfer on the input channel carries a value and a flush flag. The
// configured offset is added to the value (wrapping at the value width) and
// the Elias omega code of the sum is appended to the byte stream, earliest
// bit in bit 7 of each byte. Up to seven bits wait between items; a flush
// pads them with zeros and sends them as one more byte. A sum of zero is not
// coded: a marker transfer with zero_error set and a zero byte is sent
// instead, and it is never part of the stream. The final transfer caused by
// an item carries last_of_item; an item that fills no byte causes none.
// One item is handled at a time: the input stalls until it is closed. The
// item is accepted, then the iterative prepend unit builds one length group
// per cycle (at most four for a 32-bit value) and prepends the waiting bits
// in one more step, or sends the marker for a zero sum. The single output
// register then sends the bytes (at most seven), one byte per cycle while
// the output is not stalled, and a closing step keeps the leftover bits.
module elias_omega_encoder_unit
  import eoe_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // Configuration: offset register.
  input  logic                    cfg_we_i,
  input  logic [OFFSET_WIDTH-1:0] cfg_wdata_i,
  // Input channel.
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [VALUE_WIDTH-1:0]  value_i,
  input  logic                    flush_i,
  // Output channel.
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [BYTE_W-1:0]       out_byte_o,
  output logic                    last_of_item_o,
  output logic                    zero_error_o
);

  eoe_cmd_t    cmd;
  eoe_status_t status;

  // The controller decides what happens each cycle; the datapath holds all
  // item data and the output register, so the output side can stall freely.
  eoe_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  eoe_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .value_i        (value_i),
    .flush_i        (flush_i),
    .cmd_i          (cmd),
    .status_o       (status),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_byte_o     (out_byte_o),
    .last_of_item_o (last_of_item_o),
    .zero_error_o   (zero_error_o)
  );

endmodule

@@ hw/rtl/eoe_ctrl.sv @@
// ----------------------------------------------------------------------------
// Elias omega encoder controller
// Sequences acceptance, group building, byte output and close-out per item.
// ----------------------------------------------------------------------------
module eoe_ctrl
  import eoe_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  eoe_status_t status_i,
  output eoe_cmd_t    cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_GROUP = 4'b0010,
    S_MARK  = 4'b0100,
    S_EMIT  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_GROUP;
        end
      end
      S_GROUP: begin
        if (status_i.cur_zero) begin
          state_d = S_MARK;
        end else begin
          cmd_o.step = 1'b1;
          if (!status_i.cur_gt1) begin
            state_d = S_EMIT;
          end
        end
      end
      S_MARK: begin
        if (status_i.out_free) begin
          cmd_o.mark = 1'b1;
          state_d    = S_EMIT;
        end
      end
      S_EMIT: begin
        priority if (status_i.cnt_ge8) begin
          cmd_o.emit_byte = status_i.out_free;
        end else if (status_i.flush && status_i.cnt_nz) begin
          cmd_o.emit_pad = status_i.out_free;
        end else begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ hw/rtl/eoe_datapath.sv @@
// ----------------------------------------------------------------------------
// Elias omega encoder datapath
// Offset register, code buffer, waiting bits and the output register.
// ----------------------------------------------------------------------------
module eoe_datapath
  import eoe_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [OFFSET_WIDTH-1:0] cfg_wdata_i,
  input  logic [VALUE_WIDTH-1:0]  value_i,
  input  logic                    flush_i,
  input  eoe_cmd_t                cmd_i,
  output eoe_status_t             status_o,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [BYTE_W-1:0]       out_byte_o,
  output logic                    last_of_item_o,
  output logic                    zero_error_o
);

  logic [OFFSET_WIDTH-1:0] offset_q;
  logic [VALUE_WIDTH-1:0]  cur_q, cur_d;
  logic [BUF_W-1:0]        buf_q, buf_d;
  logic [CNT_W-1:0]        cnt_q, cnt_d;
  logic                    flush_q;
  logic [PEND_W-1:0]       pbits_q, pbits_d;
  logic [PCNT_W-1:0]       pcnt_q, pcnt_d;
  logic                    ovalid_q, ovalid_d;
  logic [BYTE_W-1:0]       obyte_q, obyte_d;
  logic                    olast_q, olast_d;
  logic                    oerr_q, oerr_d;

  logic [LEN_W-1:0]  cur_len;
  logic [CNT_W-1:0]  rem;
  logic [PCNT_W-1:0] cnt3;
  logic [PEND_W-1:0] low7;
  logic              out_free;

  assign cur_len  = bit_length(cur_q);
  assign rem      = cnt_q - CNT_W'(BYTE_W);
  assign cnt3     = cnt_q[PCNT_W-1:0];
  assign low7     = buf_q[PEND_W-1:0] & PEND_W'((8'd1 << cnt3) - 8'd1);
  assign out_free = !ovalid_q || !out_stall_i;

  assign status_o.cur_zero = (cur_q == '0);
  assign status_o.cur_gt1  = (cur_q > VALUE_WIDTH'(1));
  assign status_o.cnt_ge8  = (cnt_q >= CNT_W'(BYTE_W));
  assign status_o.cnt_nz   = (cnt_q != '0);
  assign status_o.flush    = flush_q;
  assign status_o.out_free = out_free;

  always_comb begin
    cur_d    = cur_q;
    buf_d    = buf_q;
    cnt_d    = cnt_q;
    pbits_d  = pbits_q;
    pcnt_d   = pcnt_q;
    ovalid_d = ovalid_q && out_stall_i;
    obyte_d  = obyte_q;
    olast_d  = olast_q;
    oerr_d   = oerr_q;

    if (cmd_i.load) begin
      cur_d = VALUE_WIDTH'(value_i + VALUE_WIDTH'(offset_q));
      buf_d = '0;           // the closing zero bit
      cnt_d = CNT_W'(1);
    end

    if (cmd_i.step) begin
      if (status_o.cur_gt1) begin
        // Groups are built from the value down, so each one goes in front.
        buf_d = buf_q | (BUF_W'(cur_q) << cnt_q);
        cnt_d = cnt_q + CNT_W'(cur_len);
        cur_d = VALUE_WIDTH'(cur_len - LEN_W'(1));
      end else begin
        buf_d = buf_q | (BUF_W'(pbits_q) << cnt_q);
        cnt_d = cnt_q + CNT_W'(pcnt_q);
      end
    end

    if (cmd_i.mark) begin
      ovalid_d = 1'b1;
      obyte_d  = '0;
      oerr_d   = 1'b1;
      olast_d  = !(flush_q && (pcnt_q != '0));
      buf_d    = BUF_W'(pbits_q);
      cnt_d    = CNT_W'(pcnt_q);
    end

    if (cmd_i.emit_byte) begin
      ovalid_d = 1'b1;
      obyte_d  = BYTE_W'(buf_q >> rem);
      oerr_d   = 1'b0;
      olast_d  = (rem < CNT_W'(BYTE_W)) && !(flush_q && (rem != '0));
      cnt_d    = rem;
    end

    if (cmd_i.emit_pad) begin
      ovalid_d = 1'b1;
      obyte_d  = BYTE_W'({1'b0, low7} << (4'd8 - {1'b0, cnt3}));
      oerr_d   = 1'b0;
      olast_d  = 1'b1;
      cnt_d    = '0;
    end

    if (cmd_i.finish) begin
      pbits_d = low7;
      pcnt_d  = cnt3;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= '0;
      pbits_q  <= '0;
      pcnt_q   <= '0;
      ovalid_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        offset_q <= cfg_wdata_i;
      end
      pbits_q  <= pbits_d;
      pcnt_q   <= pcnt_d;
      ovalid_q <= ovalid_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q   <= cur_d;
    buf_q   <= buf_d;
    obyte_q <= obyte_d;
    olast_q <= olast_d;
    oerr_q  <= oerr_d;
    if (cmd_i.load) begin
      flush_q <= flush_i;
    end
  end

  assign out_valid_o    = ovalid_q;
  assign out_byte_o     = obyte_q;
  assign last_of_item_o = olast_q;
  assign zero_error_o   = oerr_q;

endmodule
